FILE: hdl/lr_pkg.sv
package lr_pkg;

    localparam int SCREEN_SIDE = 512;
    localparam int COORD_W     = 12;
    localparam int DELTA_W     = 13;
    localparam int ERR_W       = 14;
    localparam int ACC_W       = 16;
    localparam int COLOR_W     = 32;
    localparam int ADDR_W      = 18;
    localparam int ADDR_FULL_W = COORD_W + $clog2(SCREEN_SIDE + 1);

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    typedef struct packed {
        logic                       kind;
        logic signed [COORD_W-1:0]  x_start;
        logic signed [COORD_W-1:0]  y_start;
        logic signed [COORD_W-1:0]  x_end;
        logic signed [COORD_W-1:0]  y_end;
        logic [COLOR_W-1:0]         color;
    } line_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]  pixel_x;
        logic signed [COORD_W-1:0]  pixel_y;
        logic [ADDR_W-1:0]          pixel_address;
        logic [COLOR_W-1:0]         pixel_color;
        logic                       visible;
        logic                       last;
    } pixel_item_t;

    typedef struct packed {
        logic                       active;
        logic signed [COORD_W-1:0]  cur_x;
        logic signed [COORD_W-1:0]  cur_y;
        logic signed [ERR_W-1:0]    err_acc;
        logic [DELTA_W-1:0]         steps_left;
        logic [DELTA_W-1:0]         major_delta;
        logic [DELTA_W-1:0]         minor_delta;
        logic                       x_major;
        logic                       y_negative;
        logic [COLOR_W-1:0]         line_color;
    } walk_state_t;

endpackage

FILE: hdl/lr_setup.sv
module lr_setup (
    input  lr_pkg::line_item_t  item,
    output lr_pkg::walk_state_t loaded
);
    import lr_pkg::*;

    logic                       swap;
    logic signed [COORD_W-1:0]  x0;
    logic signed [COORD_W-1:0]  y0;
    logic signed [COORD_W-1:0]  x1;
    logic signed [COORD_W-1:0]  y1;
    logic signed [DELTA_W-1:0]  dx;
    logic signed [DELTA_W-1:0]  dy;
    logic [DELTA_W-1:0]         ady;
    logic                       x_major;

    // The walk always runs left to right in x.
    assign swap = item.x_start > item.x_end;
    assign x0   = swap ? item.x_end   : item.x_start;
    assign y0   = swap ? item.y_end   : item.y_start;
    assign x1   = swap ? item.x_start : item.x_end;
    assign y1   = swap ? item.y_start : item.y_end;

    assign dx      = DELTA_W'(x1) - DELTA_W'(x0);
    assign dy      = DELTA_W'(y1) - DELTA_W'(y0);
    assign ady     = dy[DELTA_W-1] ? DELTA_W'(-dy) : DELTA_W'(dy);
    assign x_major = DELTA_W'(dx) >= ady;

    always_comb
    begin
        loaded.active      = 1'b1;
        loaded.cur_x       = x0;
        loaded.cur_y       = y0;
        loaded.err_acc     = '0;
        loaded.major_delta = x_major ? DELTA_W'(dx) : ady;
        loaded.minor_delta = x_major ? ady : DELTA_W'(dx);
        loaded.steps_left  = loaded.major_delta + DELTA_W'(1);
        loaded.x_major     = x_major;
        loaded.y_negative  = dy[DELTA_W-1];
        loaded.line_color  = item.color;
    end

endmodule

FILE: hdl/lr_walk.sv
module lr_walk (
    input  lr_pkg::walk_state_t cur,
    output lr_pkg::pixel_item_t pix,
    output lr_pkg::walk_state_t nxt
);
    import lr_pkg::*;

    localparam logic signed [COORD_W:0] SIDE_S = (COORD_W + 1)'(SCREEN_SIDE);

    logic signed [COORD_W:0]    x_ext;
    logic signed [COORD_W:0]    y_ext;
    logic                       vis;
    logic [ADDR_FULL_W-1:0]     addr_full;
    logic                       fin;
    logic signed [ACC_W-1:0]    two_minor;
    logic signed [ACC_W-1:0]    two_major;
    logic signed [ACC_W-1:0]    major_ext;
    logic signed [ACC_W-1:0]    err_sum;
    logic                       minor_step;
    logic signed [ACC_W-1:0]    err_new;

    assign x_ext = {cur.cur_x[COORD_W-1], cur.cur_x};
    assign y_ext = {cur.cur_y[COORD_W-1], cur.cur_y};
    assign vis   = !cur.cur_x[COORD_W-1] && !cur.cur_y[COORD_W-1]
                   && (x_ext < SIDE_S) && (y_ext < SIDE_S);

    assign addr_full = ADDR_FULL_W'(cur.cur_y[COORD_W-2:0]) * ADDR_FULL_W'(SCREEN_SIDE)
                       + ADDR_FULL_W'(cur.cur_x[COORD_W-2:0]);

    assign fin = cur.steps_left <= DELTA_W'(1);

    // Error term tracks the exact rounding point of the minor axis.
    assign two_minor  = {2'b00, cur.minor_delta, 1'b0};
    assign two_major  = {2'b00, cur.major_delta, 1'b0};
    assign major_ext  = {3'b000, cur.major_delta};
    assign err_sum    = ACC_W'(cur.err_acc) + two_minor;
    assign minor_step = err_sum >= major_ext;
    assign err_new    = minor_step ? err_sum - two_major : err_sum;

    always_comb
    begin
        pix.pixel_x       = cur.cur_x;
        pix.pixel_y       = cur.cur_y;
        pix.pixel_address = vis ? addr_full[ADDR_W-1:0] : '0;
        pix.pixel_color   = cur.line_color;
        pix.visible       = vis;
        pix.last          = fin;

        nxt = cur;
        if (fin)
        begin
            nxt.active     = 1'b0;
            nxt.steps_left = '0;
        end
        else
        begin
            nxt.err_acc    = err_new[ERR_W-1:0];
            nxt.steps_left = cur.steps_left - DELTA_W'(1);
            if (cur.x_major)
            begin
                nxt.cur_x = cur.cur_x + COORD_W'(1);
                if (minor_step)
                begin
                    nxt.cur_y = cur.y_negative ? cur.cur_y - COORD_W'(1)
                                               : cur.cur_y + COORD_W'(1);
                end
            end
            else
            begin
                nxt.cur_y = cur.y_negative ? cur.cur_y - COORD_W'(1)
                                           : cur.cur_y + COORD_W'(1);
                if (minor_step)
                begin
                    nxt.cur_x = cur.cur_x + COORD_W'(1);
                end
            end
        end
    end

endmodule

FILE: hdl/line_rasterizer.sv
// Items pass through the input register; pixels go out through the pixel register.
// Throughput: one item per cycle unless the pixel output stalls; the step logic
// between the input and pixel registers updates the line state combinationally.
// Reset: asynchronous, active low; clears the line state (no line loaded)
// and empties the input and pixel registers.
module line_rasterizer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  lr_pkg::line_item_t  item,
    output logic                pixel_valid,
    input  logic                pixel_ready,
    output lr_pkg::pixel_item_t pixel
);
    import lr_pkg::*;

    logic        in_valid_reg;
    line_item_t  in_reg;
    walk_state_t state_reg;
    walk_state_t state_next;
    walk_state_t loaded;
    walk_state_t stepped;
    pixel_item_t pix;
    logic        out_valid_reg;
    pixel_item_t out_reg;
    logic        out_free;
    logic        is_load;
    logic        emit;
    logic        advance;

    lr_setup u_setup (
        .item   (in_reg),
        .loaded (loaded)
    );

    lr_walk u_walk (
        .cur (state_reg),
        .pix (pix),
        .nxt (stepped)
    );

    assign out_free   = !out_valid_reg || pixel_ready;
    assign is_load    = in_reg.kind == KIND_LOAD;
    assign emit       = in_valid_reg && !is_load && state_reg.active;
    assign advance    = in_valid_reg && (is_load || !state_reg.active || out_free);
    assign item_ready = !in_valid_reg || advance;

    always_comb
    begin
        state_next = state_reg;
        if (advance)
        begin
            if (is_load)
            begin
                state_next = loaded;
            end
            else if (state_reg.active)
            begin
                state_next = stepped;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (item_ready)
            begin
                in_valid_reg <= item_valid;
            end
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pixel_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            in_reg <= item;
        end
        if (advance && emit)
        begin
            out_reg <= pix;
        end
    end

    assign pixel_valid = out_valid_reg;
    assign pixel       = out_reg;

endmodule

FILE: hdl/lr_checker.sv
module lr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                pixel_valid,
    input logic                pixel_ready,
    input lr_pkg::pixel_item_t pixel
);
    import lr_pkg::*;

    // The pixel register is empty while reset is held.
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !pixel_valid)
        else $error("pixel beat offered during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_ready |=> pixel_valid && $stable(pixel))
        else $error("stalled pixel beat changed");

    a_hidden_addr: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel.visible |-> pixel.pixel_address == '0)
        else $error("off-screen pixel carries an address");

    a_visible_coords: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel.visible |->
            !pixel.pixel_x[COORD_W-1] && !pixel.pixel_y[COORD_W-1])
        else $error("visible pixel with negative coordinate");

endmodule

bind line_rasterizer lr_checker u_lr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel)
);

FILE: tb/pixel_checker.sv
`timescale 1ns / 100ps

module pixel_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_ready,
    input  lr_pkg::line_item_t  item,
    input  logic                pixel_valid,
    input  logic                pixel_ready,
    input  lr_pkg::pixel_item_t pixel,
    output int                  mismatches,
    output int                  pixels_pending
);

    import lr_pkg::*;

    pixel_item_t         pixels_due[$];
    pixel_item_t         want;

    logic                line_on;
    int                  pos_x;
    int                  pos_y;
    int                  err_term;
    int                  pixels_left;
    int                  long_delta;
    int                  short_delta;
    logic                along_x;
    logic                going_down;
    logic [COLOR_W-1:0]  ink;

    task automatic report_failure(input string msg);
        $display("%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] wanted);
        if (got !== wanted)
        begin
            report_failure($sformatf("%s mismatch: got %h, expected %h", name, got, wanted));
        end
    endtask

    task automatic predict_pixel(input line_item_t it);
        int          xa;
        int          ya;
        int          xb;
        int          yb;
        int          swap;
        int          dx;
        int          dy;
        int          ady;
        int          addr;
        int          minor_step;
        logic        vis;
        pixel_item_t pix;
        if (it.kind == KIND_LOAD)
        begin
            xa = $signed(it.x_start);
            ya = $signed(it.y_start);
            xb = $signed(it.x_end);
            yb = $signed(it.y_end);
            if (xa > xb)
            begin
                swap = xa;
                xa = xb;
                xb = swap;
                swap = ya;
                ya = yb;
                yb = swap;
            end
            dx = xb - xa;
            dy = yb - ya;
            ady = (dy < 0) ? -dy : dy;
            pos_x = xa;
            pos_y = ya;
            going_down = (dy < 0);
            along_x = (dx >= ady);
            long_delta = along_x ? dx : ady;
            short_delta = along_x ? ady : dx;
            err_term = 0;
            pixels_left = long_delta + 1;
            ink = it.color;
            line_on = 1'b1;
        end
        else if (line_on)
        begin
            vis = (pos_x >= 0) && (pos_y >= 0) && (pos_x < SCREEN_SIDE) && (pos_y < SCREEN_SIDE);
            addr = vis ? pos_y * SCREEN_SIDE + pos_x : 0;
            pix.pixel_x = pos_x[COORD_W-1:0];
            pix.pixel_y = pos_y[COORD_W-1:0];
            pix.pixel_address = addr[ADDR_W-1:0];
            pix.pixel_color = ink;
            pix.visible = vis;
            pix.last = (pixels_left <= 1);
            pixels_due = {pixels_due, pix};
            if (pixels_left <= 1)
            begin
                line_on = 1'b0;
                pixels_left = 0;
            end
            else
            begin
                minor_step = 0;
                err_term += 2 * short_delta;
                if (err_term >= long_delta)
                begin
                    minor_step = 1;
                    err_term -= 2 * long_delta;
                end
                if (along_x)
                begin
                    pos_x += 1;
                    pos_y += going_down ? -minor_step : minor_step;
                end
                else
                begin
                    pos_y += going_down ? -1 : 1;
                    pos_x += minor_step;
                end
                pixels_left--;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_on = 1'b0;
            pos_x = 0;
            pos_y = 0;
            err_term = 0;
            pixels_left = 0;
            long_delta = 0;
            short_delta = 0;
            along_x = 1'b0;
            going_down = 1'b0;
            ink = '0;
            pixels_due.delete();
            mismatches = 0;
            pixels_pending = 0;
        end
        else
        begin
            if (pixel_valid && pixel_ready)
            begin
                if (pixels_due.size() == 0)
                begin
                    report_failure("pixel beat arrived with no pixel expected");
                end
                else
                begin
                    want = pixels_due.pop_front();
                    check_field("pixel_x", 32'(pixel.pixel_x), 32'(want.pixel_x));
                    check_field("pixel_y", 32'(pixel.pixel_y), 32'(want.pixel_y));
                    check_field("pixel_address", 32'(pixel.pixel_address),
                                32'(want.pixel_address));
                    check_field("pixel_color", pixel.pixel_color, want.pixel_color);
                    check_field("visible", 32'(pixel.visible), 32'(want.visible));
                    check_field("last", 32'(pixel.last), 32'(want.last));
                end
            end
            if (item_valid && item_ready)
            begin
                predict_pixel(item);
            end
            pixels_pending = pixels_due.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import lr_pkg::*;

    localparam int ITEM_TARGET = 1700;
    localparam int IDLE_LIMIT  = 2000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        item_valid = 1'b0;
    logic        item_ready;
    line_item_t  item = '0;
    logic        pixel_valid;
    logic        pixel_ready = 1'b0;
    pixel_item_t pixel;

    int          mismatches;
    int          pixels_pending;
    int          sent_count = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    int          stall_mode = 0;
    int          stall_tick = 0;

    line_rasterizer u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel)
    );

    pixel_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .item           (item),
        .pixel_valid    (pixel_valid),
        .pixel_ready    (pixel_ready),
        .pixel          (pixel),
        .mismatches     (mismatches),
        .pixels_pending (pixels_pending)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        if (stall_tick % 64 == 0)
        begin
            stall_mode = $urandom_range(0, 3);
        end
        stall_tick = stall_tick + 1;
        case (stall_mode)
            0:       pixel_ready <= 1'b1;
            1:       pixel_ready <= ($urandom_range(0, 1) == 1);
            2:       pixel_ready <= (stall_tick % 4 == 0);
            default: pixel_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (pixel_valid && pixel_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic line_item_t load_item(input int xs, input int ys, input int xe,
                                             input int ye, input logic [COLOR_W-1:0] c);
        line_item_t l;
        l.kind = KIND_LOAD;
        l.x_start = xs[COORD_W-1:0];
        l.y_start = ys[COORD_W-1:0];
        l.x_end = xe[COORD_W-1:0];
        l.y_end = ye[COORD_W-1:0];
        l.color = c;
        return l;
    endfunction

    function automatic line_item_t step_item();
        line_item_t s;
        s.kind = KIND_STEP;
        s.x_start = COORD_W'($urandom);
        s.y_start = COORD_W'($urandom);
        s.x_end = COORD_W'($urandom);
        s.y_end = COORD_W'($urandom);
        s.color = $urandom;
        return s;
    endfunction

    function automatic int pick_coord();
        case ($urandom_range(0, 3))
            0:       return int'($urandom_range(0, 4095)) - 2048;
            1:       return int'($urandom_range(0, SCREEN_SIDE - 1));
            2:       return int'($urandom_range(0, 40)) + SCREEN_SIDE - 20;
            default: return int'($urandom_range(0, 40)) - 20;
        endcase
    endfunction

    function automatic int clamp_coord(input int v);
        if (v < -2048)
        begin
            return -2048;
        end
        if (v > 2047)
        begin
            return 2047;
        end
        return v;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_item(input line_item_t it);
        if (burst_left == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        item <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        burst_left--;
        sent_count++;
        @(negedge clk);
    endtask

    initial
    begin
        int xs;
        int ys;
        int xe;
        int ye;
        int adx;
        int ady;
        int span;
        int walk;

        rst_n <= 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(step_item());
        send_item(load_item(5, 5, 5, 5, 32'h0000_0000));
        repeat (2) send_item(step_item());
        send_item(load_item(2047, -2048, -2048, 2047, 32'hFFFF_FFFF));
        repeat (2) send_item(step_item());
        send_item(load_item(SCREEN_SIDE - 2, 3, SCREEN_SIDE + 1, 9, 32'h00FF_00FF));
        repeat (4) send_item(step_item());
        send_item(load_item(0, 0, 2, 1, 32'hA5A5_5A5A));
        repeat (3) send_item(step_item());
        send_item(load_item(0, SCREEN_SIDE - 1, 2, SCREEN_SIDE - 7, 32'h1234_5678));
        repeat (3) send_item(step_item());
        send_item(load_item(-1, -1, -3, 0, 32'h8000_0001));
        repeat (2) send_item(step_item());

        // Mostly short lines walked to their end, with some cut short by a new load.
        while (sent_count < ITEM_TARGET)
        begin
            xs = pick_coord();
            ys = pick_coord();
            if ($urandom_range(0, 9) == 0)
            begin
                xe = pick_coord();
                ye = pick_coord();
            end
            else
            begin
                xe = clamp_coord(xs + int'($urandom_range(0, 32)) - 16);
                ye = clamp_coord(ys + int'($urandom_range(0, 32)) - 16);
            end
            adx = (xe > xs) ? xe - xs : xs - xe;
            ady = (ye > ys) ? ye - ys : ys - ye;
            span = ((adx > ady) ? adx : ady) + 1;
            if (span > 40 || $urandom_range(0, 7) == 0)
            begin
                walk = $urandom_range(0, (span < 12) ? span : 12);
            end
            else
            begin
                walk = span + $urandom_range(0, 2);
            end
            send_item(load_item(xs, ys, xe, ye, $urandom));
            repeat (walk) send_item(step_item());
        end
        item_valid <= 1'b0;

        while (pixels_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
        if (mismatches == 0 && pixels_pending == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

FILE: line_rasterizer.f
hdl/lr_pkg.sv
hdl/lr_setup.sv
hdl/lr_walk.sv
hdl/line_rasterizer.sv
hdl/lr_checker.sv
tb/pixel_checker.sv
tb/tb_top.sv
